>>> rtl/core/gsrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsrl_pkg
// Shared types and constants of the gain slew-rate limiter.
// ----------------------------------------------------------------------------
package gsrl_pkg;

    localparam int DATA_W    = 32;              // gain and target, Q16.16
    localparam int IDX_W     = 4;               // gain index field
    localparam int FRAC_W    = 17;              // Q1.16 fractions up to one and above
    localparam int CFG_IDX_W = 2;
    localparam int MUL_A_W   = DATA_W + 1;      // difference of two gains
    localparam int MUL_B_W   = FRAC_W + 1;      // fraction as a signed operand
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int FRAC_SH   = 16;
    localparam int FL_W      = PROD_W - FRAC_SH; // floored product
    localparam int LIM_W     = FL_W + 1;         // step, room for negation
    localparam int CMP_W     = PROD_W + 1;
    localparam int SUM_W     = LIM_W + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE_COEF = 2'd2;

    localparam logic [FRAC_W-1:0] MAX_FRAC_RST  = 17'd655;
    localparam logic [FRAC_W-1:0] MIN_FRAC_RST  = 17'd66;
    localparam logic [FRAC_W-1:0] MUTE_COEF_RST = 17'd0;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic signed [DATA_W-1:0] GAIN_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] GAIN_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULA,
        ST_MULB,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic accept;   // item taken, bank read issued
        logic first;    // first multiplier pass
        logic second;   // second multiplier pass
        logic finish;   // result formed, written back
    } t_ctrl;

endpackage

>>> rtl/core/gsrl_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsrl_bank
// Gain storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gsrl_bank #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rd_en,
    input  logic [AW-1:0]                        i_rd_addr,
    output logic signed [gsrl_pkg::DATA_W-1:0]   o_rd_data,
    input  logic                                 i_wr_en,
    input  logic [AW-1:0]                        i_wr_addr,
    input  logic signed [gsrl_pkg::DATA_W-1:0]   i_wr_data
);
    import gsrl_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/gsrl_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsrl_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module gsrl_mul (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [gsrl_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [gsrl_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [gsrl_pkg::PROD_W-1:0]   o_p
);
    import gsrl_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

>>> rtl/core/gsrl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsrl_ctrl
// Sequencer: read, two multiplier passes, finish and write back.
// ----------------------------------------------------------------------------
module gsrl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output gsrl_pkg::t_ctrl  o_ctrl
);
    import gsrl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_MULA;
                end
            end
            ST_MULA: n_state = ST_MULB;
            ST_MULB: n_state = ST_FIN;
            ST_FIN:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        busy   = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy          = 1'b0;
                o_ctrl.accept = start;
            end
            ST_MULA: o_ctrl.first  = 1'b1;
            ST_MULB: o_ctrl.second = 1'b1;
            ST_FIN:  o_ctrl.finish = 1'b1;
            default: busy = 1'b1;
        endcase
    end

endmodule

>>> rtl/core/gain_slew_rate_limiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_slew_rate_limiter_top
// Bank of Q16.16 controller gains, each moved toward a target at a limited
// relative rate per step beat.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. Every beat, in range or
// not, gives exactly one result on o_result_index / o_new_gain, marked by
// o_strobe for one cycle; it follows the states MULA, MULB and FIN and the
// result register; the result cannot be held off, so sample it when o_strobe
// is high. A beat, taken only while none is in flight, runs through the bank
// read, two passes through the single shared multiplier (limit product, then
// minimum-fraction product) and the finishing cycle that forms the saturated
// gain and writes it back. busy drops in the cycle the result is shown, so a
// new beat may start then. Configuration writes (i_cfg_we, i_cfg_idx,
// i_cfg_wdata) take effect at once; issue them only while no beat is in
// flight. A gain must be loaded before it is stepped: the bank is not
// cleared by reset. Indexes at or above NUM_GAINS write nothing and return 0.
// ----------------------------------------------------------------------------
module gain_slew_rate_limiter_top #(
    parameter int NUM_GAINS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // command channel
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_operation,
    input  logic [gsrl_pkg::IDX_W-1:0]             i_gain_index,
    input  logic signed [gsrl_pkg::DATA_W-1:0]     i_target,
    input  logic                                   i_lateral,
    input  logic                                   i_mute_active,
    input  logic                                   i_after_toggle,
    // result channel
    output logic                                   o_strobe,
    output logic [gsrl_pkg::IDX_W-1:0]             o_result_index,
    output logic signed [gsrl_pkg::DATA_W-1:0]     o_new_gain,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [gsrl_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [gsrl_pkg::FRAC_W-1:0]            i_cfg_wdata
);
    import gsrl_pkg::*;

    localparam int AW = (NUM_GAINS > 1) ? $clog2(NUM_GAINS) : 1;

    t_ctrl w_ctrl;

    // configuration registers
    logic [FRAC_W-1:0] r_max_frac;
    logic [FRAC_W-1:0] r_min_frac;
    logic [FRAC_W-1:0] r_mute_coef;

    // captured beat
    logic                     r_op;
    logic [IDX_W-1:0]         r_idx;
    logic signed [DATA_W-1:0] r_target;
    logic                     r_byp;        // lateral, muted or just unmuted
    logic                     r_lat_mute;   // lateral and muted: scale target

    // working registers
    logic signed [DATA_W-1:0]  r_cur;
    logic                      r_cur_zero;
    logic signed [MUL_A_W-1:0] r_change;
    logic signed [LIM_W-1:0]   r_lim;

    // result registers
    logic                     r_strobe;
    logic [IDX_W-1:0]         r_res_idx;
    logic signed [DATA_W-1:0] r_new_gain;

    logic signed [DATA_W-1:0]  w_rd_data;
    logic signed [MUL_A_W-1:0] w_tgt_ext;
    logic signed [MUL_A_W-1:0] w_cur_ext;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [FL_W-1:0]    w_prod_fl;
    logic signed [CMP_W-1:0]   w_prod_ext;
    logic signed [CMP_W-1:0]   w_prod_abs;
    logic signed [MUL_A_W:0]   w_sgn_change;
    logic signed [CMP_W-1:0]   w_scaled;
    logic signed [CMP_W-1:0]   w_lim_ext;
    logic signed [CMP_W-1:0]   w_lim_abs;
    logic                      w_plain;
    logic                      w_use_min;
    logic signed [SUM_W-1:0]   w_step;
    logic signed [SUM_W-1:0]   w_base;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [DATA_W-1:0]  w_sat;
    logic                      w_in_range;
    logic signed [DATA_W-1:0]  w_result;

    gsrl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_ctrl  (w_ctrl)
    );

    // Configuration writes; index three is unused.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frac  <= MAX_FRAC_RST;
            r_min_frac  <= MIN_FRAC_RST;
            r_mute_coef <= MUTE_COEF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAX_FRAC:  r_max_frac  <= i_cfg_wdata;
                REG_MIN_FRAC:  r_min_frac  <= i_cfg_wdata;
                REG_MUTE_COEF: r_mute_coef <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Capture the beat; the bank read goes out on the same edge.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.accept) begin
            r_op       <= i_operation;
            r_idx      <= i_gain_index;
            r_target   <= i_target;
            r_byp      <= i_lateral && (i_mute_active || i_after_toggle);
            r_lat_mute <= i_lateral && i_mute_active;
        end
    end

    assign w_in_range = (32'(r_idx) < NUM_GAINS);

    gsrl_bank #(
        .DEPTH (NUM_GAINS),
        .AW    (AW)
    ) u_bank (
        .i_clk     (i_clk),
        .i_rd_en   (w_ctrl.accept),
        .i_rd_addr (AW'(i_gain_index)),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_ctrl.finish && w_in_range),
        .i_wr_addr (AW'(r_idx)),
        .i_wr_data (w_result)
    );

    assign w_tgt_ext = MUL_A_W'(r_target);
    assign w_cur_ext = MUL_A_W'(w_rd_data);

    // First pass: target times mute scale when lateral and muted, target times
    // max fraction on other bypass or for a zero gain (the difference is the
    // target), else gain times max fraction, which is the signed step limit.
    // Second pass: difference times min fraction.
    always_comb begin
        if (w_ctrl.second) begin
            w_mul_a = r_change;
            w_mul_b = MUL_B_W'(r_min_frac);
        end else begin
            w_mul_a = (r_byp || (w_rd_data == '0)) ? w_tgt_ext : w_cur_ext;
            w_mul_b = r_lat_mute ? MUL_B_W'(r_mute_coef) : MUL_B_W'(r_max_frac);
        end
    end

    gsrl_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_ctrl.first || w_ctrl.second),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // Hold the current gain and the difference for later passes.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.first) begin
            r_cur      <= w_rd_data;
            r_cur_zero <= (w_rd_data == '0);
            r_change   <= w_tgt_ext - w_cur_ext;
        end
    end

    // Product floored to Q16.16, and its magnitude at full scale.
    assign w_prod_fl  = w_prod[PROD_W-1:FRAC_SH];
    assign w_prod_ext = CMP_W'(w_prod);
    assign w_prod_abs = w_prod_ext[CMP_W-1] ? -w_prod_ext : w_prod_ext;

    // Difference seen in the direction of the gain's sign, scaled by one.
    assign w_sgn_change = r_cur[DATA_W-1] ? -(MUL_A_W + 1)'(r_change)
                                          : (MUL_A_W + 1)'(r_change);
    assign w_scaled     = CMP_W'(w_sgn_change) <<< FRAC_SH;

    // Pick the limited step once the limit product is in.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.second) begin
            if (r_byp) begin
                r_lim <= r_lat_mute ? LIM_W'(w_prod_fl) : LIM_W'(r_target);
            end else if (r_cur_zero) begin
                r_lim <= LIM_W'(w_prod_fl);
            end else if (w_scaled > w_prod_abs) begin
                r_lim <= LIM_W'(w_prod_fl);
            end else if (w_scaled < -w_prod_abs) begin
                r_lim <= -LIM_W'(w_prod_fl);
            end else begin
                r_lim <= LIM_W'(r_change);
            end
        end
    end

    // Finish: fall back to the min fraction when the limited step is too small,
    // add the current gain unless bypassed or zero, and saturate.
    assign w_plain   = !r_byp && !r_cur_zero;
    assign w_lim_ext = CMP_W'(r_lim);
    assign w_lim_abs = w_lim_ext[CMP_W-1] ? -w_lim_ext : w_lim_ext;
    assign w_use_min = w_plain && ((w_lim_abs <<< FRAC_SH) < w_prod_abs);
    assign w_step    = w_use_min ? SUM_W'(w_prod_fl) : SUM_W'(r_lim);
    assign w_base    = w_plain ? SUM_W'(r_cur) : '0;
    assign w_sum     = w_step + w_base;

    always_comb begin
        if (w_sum > SUM_W'(GAIN_MAX)) begin
            w_sat = GAIN_MAX;
        end else if (w_sum < SUM_W'(GAIN_MIN)) begin
            w_sat = GAIN_MIN;
        end else begin
            w_sat = w_sum[DATA_W-1:0];
        end
    end

    always_comb begin
        if (!w_in_range) begin
            w_result = '0;
        end else if (r_op == OP_LOAD) begin
            w_result = r_target;
        end else begin
            w_result = w_sat;
        end
    end

    // Result beat, shown for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_ctrl.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.finish) begin
            r_res_idx  <= r_idx;
            r_new_gain <= w_result;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_result_index = r_res_idx;
    assign o_new_gain     = r_new_gain;

endmodule

>>> rtl/core/gsrl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsrl_checker
// Port-level timing checks of the gain slew-rate limiter.
// ----------------------------------------------------------------------------
module gsrl_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           o_strobe,
    input  logic [gsrl_pkg::IDX_W-1:0]     i_gain_index,
    input  logic [gsrl_pkg::IDX_W-1:0]     o_result_index
);
    import gsrl_pkg::*;

    // A taken beat makes the block busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a beat was taken");

    // Every beat is answered by a result beat.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("result beat missing four cycles after accept");

    // The result carries the index of the beat that caused it.
    a_result_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(start && !busy, 4)) |->
            (o_result_index == $past(i_gain_index, 4)))
        else $error("result index does not match the accepted beat");

    // A result only ends a busy period.
    a_strobe_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (!busy && $past(busy)))
        else $error("result beat outside the end of a busy period");

endmodule

bind gain_slew_rate_limiter_top gsrl_checker u_gsrl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .i_gain_index   (i_gain_index),
    .o_result_index (o_result_index)
);
